// File: design/tpss_pkg.sv
// shared types and constants for the touch panel sample sequencer
`timescale 1ns / 1ps

package tpss_pkg;

    localparam int SAMPLES_PER_POINT = 4;
    localparam int SAMPLE_W = 10;
    localparam int SUM_W = 12;
    localparam int MODE_W = 2;
    localparam int CNT_W = $clog2(SAMPLES_PER_POINT + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_UNCHANGED = 2'd0,
        MODE_WAIT_DOWN = 2'd1,
        MODE_WAIT_UP   = 2'd2,
        MODE_AUTO      = 2'd3
    } mode_t;

    typedef enum logic {
        OP_IRQ  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                adc_done;
        logic                pen_down;
        logic                pen_up;
        logic [SAMPLE_W-1:0] x_sample;
        logic [SAMPLE_W-1:0] y_sample;
    } cmd_t;

endpackage

// File: design/tpss_req_if.sv
// request channel: interrupt and read beats
`timescale 1ns / 1ps

interface tpss_req_if
    import tpss_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                func;
    logic                adc_pending;
    logic                touch_pending;
    logic                x_pen_up;
    logic                y_pen_up;
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;

    modport source (
        output valid, func, adc_pending, touch_pending, x_pen_up, y_pen_up,
               x_sample, y_sample,
        input  ready
    );

    modport sink (
        input  valid, func, adc_pending, touch_pending, x_pen_up, y_pen_up,
               x_sample, y_sample,
        output ready
    );
endinterface

// File: design/tpss_rsp_if.sv
// response channel: one result beat per request
`timescale 1ns / 1ps

interface tpss_rsp_if
    import tpss_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] panel_mode;
    logic              start_conversion;
    logic              event_ready;
    logic              event_valid;
    logic [SUM_W-1:0]  event_x;
    logic [SUM_W-1:0]  event_y;
    logic              event_press;

    modport source (
        output valid, panel_mode, start_conversion, event_ready, event_valid,
               event_x, event_y, event_press,
        input  ready
    );

    modport sink (
        input  valid, panel_mode, start_conversion, event_ready, event_valid,
               event_x, event_y, event_press,
        output ready
    );
endinterface

// File: design/tpss_front.sv
// front stage: accepts request beats and decodes them into commands
`timescale 1ns / 1ps

module tpss_front
    import tpss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tpss_req_if.sink   req,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    assign req.ready = !valid_reg || cmd_ready;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        cmd_next          = cmd_reg;
        valid_next        = valid_reg && !cmd_ready;
        if (take)
        begin
            valid_next        = 1'b1;
            cmd_next.op       = req.func ? OP_READ : OP_IRQ;
            cmd_next.adc_done = req.adc_pending;
            cmd_next.pen_down = req.touch_pending && !req.x_pen_up && !req.y_pen_up;
            cmd_next.pen_up   = req.touch_pending && (req.x_pen_up || req.y_pen_up);
            cmd_next.x_sample = req.x_sample;
            cmd_next.y_sample = req.y_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// File: design/tpss_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module tpss_queue
    import tpss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/tpss_back.sv
// back stage: panel state, sample sums, event flags and result register
`timescale 1ns / 1ps

module tpss_back
    import tpss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    tpss_rsp_if.source rsp
);

    logic             owns_reg,  owns_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] x_sum_reg, x_sum_next;
    logic [SUM_W-1:0] y_sum_reg, y_sum_next;
    logic [SUM_W-1:0] x_lat_reg, x_lat_next;
    logic [SUM_W-1:0] y_lat_reg, y_lat_next;
    logic             down_reg,  down_next;
    logic             up_reg,    up_next;

    logic             out_valid_reg;
    mode_t            mode_reg,  mode_next;
    logic             start_reg, start_next;
    logic             ready_reg, ready_next;
    logic             evv_reg,   evv_next;
    logic [SUM_W-1:0] evx_reg,   evx_next;
    logic [SUM_W-1:0] evy_reg,   evy_next;
    logic             press_reg, press_next;

    logic             fire;
    logic [CNT_W-1:0] count_inc;

    assign cmd_ready = !out_valid_reg || rsp.ready;
    assign fire      = cmd_valid && cmd_ready;
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        owns_next  = owns_reg;
        count_next = count_reg;
        x_sum_next = x_sum_reg;
        y_sum_next = y_sum_reg;
        x_lat_next = x_lat_reg;
        y_lat_next = y_lat_reg;
        down_next  = down_reg;
        up_next    = up_reg;
        mode_next  = MODE_UNCHANGED;
        start_next = 1'b0;
        evv_next   = 1'b0;
        evx_next   = '0;
        evy_next   = '0;
        press_next = 1'b0;

        unique case (cmd.op)
            OP_IRQ:
            begin
                if (cmd.adc_done && owns_reg && count_reg < CNT_W'(SAMPLES_PER_POINT))
                begin
                    x_sum_next = x_sum_reg + {{(SUM_W - SAMPLE_W){1'b0}}, cmd.x_sample};
                    y_sum_next = y_sum_reg + {{(SUM_W - SAMPLE_W){1'b0}}, cmd.y_sample};
                    count_next = count_inc;
                    if (count_inc < CNT_W'(SAMPLES_PER_POINT))
                    begin
                        mode_next  = MODE_AUTO;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        x_lat_next = x_sum_next;
                        y_lat_next = y_sum_next;
                        down_next  = 1'b1;
                        x_sum_next = '0;
                        y_sum_next = '0;
                        count_next = '0;
                        mode_next  = MODE_WAIT_UP;
                    end
                end
                if (cmd.pen_down)
                begin
                    owns_next  = 1'b1;
                    mode_next  = MODE_AUTO;
                    start_next = 1'b1;
                end
                else if (cmd.pen_up)
                begin
                    owns_next  = 1'b0;
                    up_next    = 1'b1;
                    x_sum_next = '0;
                    y_sum_next = '0;
                    count_next = '0;
                    mode_next  = MODE_WAIT_DOWN;
                end
            end
            OP_READ:
            begin
                priority if (down_reg)
                begin
                    evv_next   = 1'b1;
                    evx_next   = x_lat_reg;
                    evy_next   = y_lat_reg;
                    press_next = 1'b1;
                    down_next  = 1'b0;
                end
                else if (up_reg)
                begin
                    evv_next   = 1'b1;
                    evx_next   = x_lat_reg;
                    evy_next   = y_lat_reg;
                    up_next    = 1'b0;
                end
                else
                begin
                    evv_next   = 1'b0;
                end
            end
            default:
            begin
                evv_next = 1'b0;
            end
        endcase

        ready_next = down_next || up_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owns_reg      <= 1'b0;
            count_reg     <= '0;
            x_sum_reg     <= '0;
            y_sum_reg     <= '0;
            x_lat_reg     <= '0;
            y_lat_reg     <= '0;
            down_reg      <= 1'b0;
            up_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                owns_reg  <= owns_next;
                count_reg <= count_next;
                x_sum_reg <= x_sum_next;
                y_sum_reg <= y_sum_next;
                x_lat_reg <= x_lat_next;
                y_lat_reg <= y_lat_next;
                down_reg  <= down_next;
                up_reg    <= up_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            ready_reg <= ready_next;
            evv_reg   <= evv_next;
            evx_reg   <= evx_next;
            evy_reg   <= evy_next;
            press_reg <= press_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.panel_mode       = mode_reg;
    assign rsp.start_conversion = start_reg;
    assign rsp.event_ready      = ready_reg;
    assign rsp.event_valid      = evv_reg;
    assign rsp.event_x          = evx_reg;
    assign rsp.event_y          = evy_reg;
    assign rsp.event_press      = press_reg;

endmodule

// File: design/touch_panel_sample_sequencer_unit.sv
// top level of the touch panel sample sequencer
//
//   channel  dir  beat
//   req      in   func, adc_pending, touch_pending, x_pen_up, y_pen_up, x_sample, y_sample
//   rsp      out  panel_mode, start_conversion, event_ready, event_valid, event_x,
//                 event_y, event_press
//
// one beat per cycle sustained while rsp.ready is high; rsp.valid rises once a beat
// has passed the decode register, two-entry command queue and back-stage result register
// reset clears panel state, sums, event flags and all handshake valid bits at once
// a stalled rsp fills the result register, then the queue, then the decode register
// before req.ready drops
`timescale 1ns / 1ps

module touch_panel_sample_sequencer_unit
    import tpss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tpss_req_if.sink   req,
    tpss_rsp_if.source rsp
);

    logic dec_valid;
    logic dec_ready;
    cmd_t dec_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    tpss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (dec_valid),
        .cmd_ready (dec_ready),
        .cmd       (dec_cmd)
    );

    tpss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (dec_valid),
        .push_ready (dec_ready),
        .push_cmd   (dec_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    tpss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .rsp       (rsp)
    );

endmodule
